/* design/ccrg_pkg.sv */
// Package for the ChaCha20 random generator: op codes, constants, item types, round functions.
// No dependencies.
`default_nettype none
package ccrg_pkg;
	localparam logic [1:0] OP_ABSORB = 2'd0;
	localparam logic [1:0] OP_JITTER = 2'd1;
	localparam logic [1:0] OP_GEN    = 2'd2;
	localparam logic [1:0] OP_REKEY  = 2'd3;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam int unsigned POS_WRAP = 768;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  entropy_byte;
		logic        first_byte;
		logic        last_item;
		logic [63:0] jitter_stamp;
		logic [2:0]  jitter_slot;
	} in_item_t;

	typedef struct packed {
		logic [63:0] random_word;
		logic [2:0]  word_slot;
		logic        block_end;
		logic        status_busy;
	} out_item_t;

	typedef logic [15:0][31:0] blk_t;

	function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [127:0] qr(input logic [31:0] a_i, input logic [31:0] b_i,
		input logic [31:0] c_i, input logic [31:0] d_i);
		logic [31:0] a, b, c, d;
		a = a_i; b = b_i; c = c_i; d = d_i;
		a = a + b; d = rol(d ^ a, 16);
		c = c + d; b = rol(b ^ c, 12);
		a = a + b; d = rol(d ^ a, 8);
		c = c + d; b = rol(b ^ c, 7);
		return {a, b, c, d};
	endfunction
endpackage
`default_nettype wire

/* design/ccrg_if.sv */
// Valid/ready channel interface carrying one item of type T.
// No package dependency; the item type T is a parameter.
`default_nettype none
interface ccrg_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/ccrg_core.sv */
// ChaCha20 block core: one shared column/diagonal round unit, iterated.
// Depends on ccrg_pkg.
`default_nettype none
module ccrg_core #(
	parameter int unsigned DOUBLE_ROUNDS = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ccrg_pkg::blk_t init,
	output logic               done,
	output ccrg_pkg::blk_t     result
);
	localparam int unsigned HR = 2 * DOUBLE_ROUNDS;
	localparam int unsigned CW = $clog2(HR + 1);

	ccrg_pkg::blk_t x_q, init_q, nx;
	logic [CW-1:0] cnt_q;
	logic run_q;
	logic [127:0] q0, q1, q2, q3;
	logic diag;

	assign diag = cnt_q[0];

	always_comb begin
		nx = x_q;
		if (!diag) begin
			q0 = ccrg_pkg::qr(x_q[0], x_q[4], x_q[8], x_q[12]);
			q1 = ccrg_pkg::qr(x_q[1], x_q[5], x_q[9], x_q[13]);
			q2 = ccrg_pkg::qr(x_q[2], x_q[6], x_q[10], x_q[14]);
			q3 = ccrg_pkg::qr(x_q[3], x_q[7], x_q[11], x_q[15]);
			{nx[0], nx[4], nx[8], nx[12]} = q0;
			{nx[1], nx[5], nx[9], nx[13]} = q1;
			{nx[2], nx[6], nx[10], nx[14]} = q2;
			{nx[3], nx[7], nx[11], nx[15]} = q3;
		end else begin
			q0 = ccrg_pkg::qr(x_q[0], x_q[5], x_q[10], x_q[15]);
			q1 = ccrg_pkg::qr(x_q[1], x_q[6], x_q[11], x_q[12]);
			q2 = ccrg_pkg::qr(x_q[2], x_q[7], x_q[8], x_q[13]);
			q3 = ccrg_pkg::qr(x_q[3], x_q[4], x_q[9], x_q[14]);
			{nx[0], nx[5], nx[10], nx[15]} = q0;
			{nx[1], nx[6], nx[11], nx[12]} = q1;
			{nx[2], nx[7], nx[8], nx[13]} = q2;
			{nx[3], nx[4], nx[9], nx[14]} = q3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			if (cnt_q == CW'(HR - 1)) run_q <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= init;
			init_q <= init;
		end else if (run_q) begin
			x_q <= nx;
		end
	end

	assign done = run_q && (cnt_q == CW'(HR - 1));

	always_comb begin
		for (int i = 0; i < 16; i++) result[i] = nx[i] + init_q[i];
	end
endmodule
`default_nettype wire

/* design/chacha20_random_generator_core.sv */
// Top level of the ChaCha20 random generator with fast key erasure.
// Depends on ccrg_pkg, ccrg_if and ccrg_core.
//
// Channels: one input item channel (op, entropy byte, flags, jitter sample)
// and one result item channel (64-bit word, slot, block end, busy status).
// Absorb items update key and nonce, jitter items update the key only; an
// absorb with last_item, or jitter slot 7, then runs a rekey block.
// A block runs 2*DOUBLE_ROUNDS half-rounds on the shared round unit (four
// quarter-rounds per cycle, column then diagonal) after loading its state.
// Generate items emit eight result items after their block, one per cycle
// while the receiver takes them, then a rekey block if last_item is set.
// Rekey-only items give one status result after the rekey block.
// The input is not ready while an item works.
// Reset: key and nonce zero, counter one, unseeded, absorb position zero.
// If the receiver stalls, the current result item holds in the output
// register and the sequencer waits; nothing is dropped.
`default_nettype none
module chacha20_random_generator_core #(
	parameter int unsigned DOUBLE_ROUNDS = 10
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ccrg_if.sink      in_ch,
	ccrg_if.source    out_ch
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_GEN   = 3'd1;
	localparam logic [2:0] ST_EMIT  = 3'd2;
	localparam logic [2:0] ST_REKEY = 3'd3;
	localparam logic [2:0] ST_STAT  = 3'd4;

	logic [2:0] state_q;
	logic [7:0][31:0] key_q;
	logic [2:0][31:0] nonce_q;
	logic [31:0] ctr_q;
	logic seeded_q;
	logic [9:0] pos_q;
	// Absorb position mod 12, kept as its own counter (768 is a multiple of 12)
	logic [3:0] q12_q;
	logic busy_q, last_q, stat_q;
	logic run_q;
	ccrg_pkg::blk_t blk_q, init_w, res_w;
	logic [2:0] slot_q;
	logic ovalid_q;
	ccrg_pkg::out_item_t odata_q;
	logic core_start, core_done;
	ccrg_pkg::in_item_t it;

	assign it = in_ch.data;
	assign in_ch.ready = (state_q == ST_IDLE);

	always_comb begin
		init_w[0] = ccrg_pkg::SIGMA0;
		init_w[1] = ccrg_pkg::SIGMA1;
		init_w[2] = ccrg_pkg::SIGMA2;
		init_w[3] = ccrg_pkg::SIGMA3;
		for (int i = 0; i < 8; i++) init_w[4 + i] = key_q[i];
		init_w[12] = ctr_q;
		init_w[13] = nonce_q[0];
		init_w[14] = nonce_q[1];
		init_w[15] = nonce_q[2];
	end

	ccrg_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(core_start), .init(init_w),
		.done(core_done), .result(res_w)
	);

	// Start the round unit in the first cycle in a block state, while it is idle.
	assign core_start = ((state_q == ST_GEN) || (state_q == ST_REKEY)) && !run_q;

	logic accept;
	logic [9:0] p_w;
	logic [3:0] q_w;
	logic [7:0] nb_w;
	assign accept = in_ch.valid && in_ch.ready;
	assign p_w = it.first_byte ? 10'd0 : pos_q;
	assign q_w = it.first_byte ? 4'd0 : q12_q;
	assign nb_w = it.entropy_byte + p_w[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_q <= '0;
			nonce_q <= '0;
			ctr_q <= 32'd1;
			seeded_q <= 1'b0;
			pos_q <= '0;
			q12_q <= '0;
			run_q <= 1'b0;
			ovalid_q <= 1'b0;
			odata_q <= '0;
			blk_q <= '0;
			slot_q <= '0;
			busy_q <= 1'b0;
			last_q <= 1'b0;
			stat_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			if (core_start) run_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						busy_q <= !seeded_q;
						last_q <= it.last_item;
						stat_q <= 1'b0;
						case (it.op)
							ccrg_pkg::OP_ABSORB: begin
								key_q[p_w[4:2]][8*p_w[1:0] +: 8] <=
									key_q[p_w[4:2]][8*p_w[1:0] +: 8] ^ it.entropy_byte;
								nonce_q[q_w[3:2]][8*q_w[1:0] +: 8] <=
									nonce_q[q_w[3:2]][8*q_w[1:0] +: 8] ^ nb_w;
								pos_q <= (p_w == 10'(ccrg_pkg::POS_WRAP - 1)) ? 10'd0
									: p_w + 10'd1;
								q12_q <= (q_w == 4'd11) ? 4'd0 : q_w + 4'd1;
								if (it.last_item) begin
									seeded_q <= 1'b1;
									state_q <= ST_REKEY;
								end
							end
							ccrg_pkg::OP_JITTER: begin
								for (int j = 0; j < 8; j++)
									key_q[{it.jitter_slot[1:0], 1'b0} + 3'(j / 4)][8*(j % 4) +: 8]
										<= key_q[{it.jitter_slot[1:0], 1'b0} + 3'(j / 4)]
										[8*(j % 4) +: 8] ^ it.jitter_stamp[8*j +: 8];
								if (it.jitter_slot == 3'd7) state_q <= ST_REKEY;
							end
							ccrg_pkg::OP_GEN: state_q <= ST_GEN;
							default: begin
								stat_q <= 1'b1;
								state_q <= ST_REKEY;
							end
						endcase
					end
				end
				ST_GEN: begin
					if (core_done) begin
						run_q <= 1'b0;
						blk_q <= res_w;
						ctr_q <= ctr_q + 32'd1;
						slot_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!ovalid_q || out_ch.ready) begin
						ovalid_q <= 1'b1;
						odata_q.random_word <= {blk_q[{slot_q, 1'b1}], blk_q[{slot_q, 1'b0}]};
						odata_q.word_slot <= slot_q;
						odata_q.block_end <= (slot_q == 3'd7);
						odata_q.status_busy <= busy_q;
						slot_q <= slot_q + 3'd1;
						if (slot_q == 3'd7) state_q <= last_q ? ST_REKEY : ST_IDLE;
					end
				end
				ST_REKEY: begin
					if (core_done) begin
						run_q <= 1'b0;
						for (int i = 0; i < 8; i++) key_q[i] <= res_w[i];
						for (int i = 0; i < 3; i++) nonce_q[i] <= nonce_q[i] ^ res_w[8 + i];
						ctr_q <= ctr_q + 32'd1;
						state_q <= stat_q ? ST_STAT : ST_IDLE;
					end
				end
				ST_STAT: begin
					if (!ovalid_q || out_ch.ready) begin
						ovalid_q <= 1'b1;
						odata_q <= '0;
						odata_q.status_busy <= busy_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data = odata_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !run_q) else $error("ready while round unit runs");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
		else $error("result item changed under stall");
	a_ctr: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |=> (ctr_q == $past(ctr_q) + 32'd1)) else $error("counter not advanced");
	a_seed: assert property (@(posedge clk) disable iff (!arst_n)
		$past(seeded_q) |-> seeded_q) else $error("seeded flag cleared");
endmodule
`default_nettype wire
